// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the console RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/tccs_pkg.sv =====
// Package for the text console: field widths, codes and the command word
// passed from front end to back end. Used by every console module.
package tccs_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int ADDR_W   = COL_W + ROW_W;
    localparam int CELL_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int Q_DEPTH  = 2;

    localparam logic [KIND_W-1:0] KIND_PUT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CELL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
    localparam logic [BYTE_W-1:0] TEXT_COLOR_RST = 8'h07;

    localparam logic REG_TEXT_COLOR = 1'b0;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              scroll;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
        logic [ADDR_W-1:0] clr_addr;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              bad;
    } t_cmd;

endpackage

// ===== rtl/tccs_front.sv =====
// Front end: accepts items, tracks cursor and scroll base row, turns each
// item into a command word. Depends on tccs_pkg.
module tccs_front
    import tccs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [BYTE_W-1:0] i_char_code,
    input  logic [BYTE_W-1:0] i_entry_color,
    input  logic [COL_W-1:0]  i_pos_column,
    input  logic [ROW_W-1:0]  i_pos_row,
    input  logic [BYTE_W-1:0] i_text_color,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [ROW_W-1:0] r_base, n_base;

    logic [ROW_W:0]    w_sum;
    logic [ROW_W-1:0]  w_prow;
    logic [ADDR_W-1:0] w_cur_addr;
    logic [ADDR_W-1:0] w_pos_addr;
    logic              w_on_screen;
    logic              w_last_row;

    assign w_sum  = {1'b0, r_row} + {1'b0, r_base};
    assign w_prow = (w_sum >= (ROW_W+1)'(ROWS)) ? w_sum[ROW_W-1:0] - ROW_W'(ROWS)
                                                 : w_sum[ROW_W-1:0];
    assign w_cur_addr = ADDR_W'(w_prow) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);

    // Direct positions are absolute rows of the visible screen.
    logic [ROW_W:0]   w_psum;
    logic [ROW_W-1:0] w_pprow;
    assign w_psum  = {1'b0, i_pos_row} + {1'b0, r_base};
    assign w_pprow = (w_psum >= (ROW_W+1)'(ROWS)) ? w_psum[ROW_W-1:0] - ROW_W'(ROWS)
                                                   : w_psum[ROW_W-1:0];
    assign w_pos_addr = ADDR_W'(w_pprow) * ADDR_W'(COLUMNS) + ADDR_W'(i_pos_column);

    assign w_on_screen = ({1'b0, i_pos_column} < (COL_W+1)'(COLUMNS)) &&
                         ({1'b0, i_pos_row} < (ROW_W+1)'(ROWS));
    assign w_last_row  = (r_row == ROW_W'(ROWS - 1));

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_base = r_base;
        o_cmd          = '0;
        o_cmd.op       = OP_NONE;
        o_cmd.clr_addr = ADDR_W'(r_base) * ADDR_W'(COLUMNS);
        unique case (i_kind)
            KIND_PUT: begin
                if (i_char_code == NEWLINE_CODE) begin
                    n_col = '0;
                    n_row = w_last_row ? '0 : r_row + ROW_W'(1);
                end else begin
                    o_cmd.op   = OP_WRITE;
                    o_cmd.addr = w_cur_addr;
                    o_cmd.data = {i_text_color, i_char_code};
                    if (r_col == COL_W'(COLUMNS - 1)) begin
                        n_col = '0;
                        if (w_last_row) begin
                            o_cmd.scroll = 1'b1;
                            n_base = (r_base == ROW_W'(ROWS - 1)) ? '0
                                                                   : r_base + ROW_W'(1);
                        end else begin
                            n_row = r_row + ROW_W'(1);
                        end
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
            end
            KIND_CELL: begin
                if (w_on_screen) begin
                    o_cmd.op   = OP_WRITE;
                    o_cmd.addr = w_pos_addr;
                    o_cmd.data = {i_entry_color, i_char_code};
                end else begin
                    o_cmd.bad = 1'b1;
                end
            end
            KIND_READ: begin
                if (w_on_screen) begin
                    o_cmd.op   = OP_READ;
                    o_cmd.addr = w_pos_addr;
                end else begin
                    o_cmd.bad = 1'b1;
                end
            end
            default: begin
            end
        endcase
        o_cmd.col = n_col;
        o_cmd.row = n_row;
    end

    assign o_push = i_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_base <= '0;
        end else if (i_accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_base <= n_base;
        end
    end

endmodule

// ===== rtl/tccs_fifo.sv =====
// Short command queue between front end and back end.
// Depends on tccs_pkg for the command word and depth.
module tccs_fifo
    import tccs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_cmd
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_data [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_cmd   = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/tccs_back.sv =====
// Back end: screen memory, reset fill pass, row clear on scroll, result word.
// Depends on tccs_pkg.
module tccs_back
    import tccs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_done,
    output logic [CELL_W-1:0] o_cell_value,
    output logic [COL_W-1:0]  o_cursor_column,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic              o_scrolled,
    output logic              o_bad_position
);

    localparam int CELLS = COLUMNS * ROWS;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_IDLE,
        ST_READ,
        ST_ZERO
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_cnt;
    logic [COL_W-1:0]  r_zcol;
    logic              r_done;
    logic [CELL_W-1:0] r_cell;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic              r_scrolled;
    logic              r_bad;

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    logic              w_we;
    logic [ADDR_W-1:0] w_addr;
    logic [CELL_W-1:0] w_wdata;

    assign o_pop      = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_clearing = (r_state == ST_FILL);

    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_cnt;
        w_wdata = '0;
        unique case (r_state)
            ST_FILL: begin
                w_we    = 1'b1;
                w_wdata = BLANK_CELL;
            end
            ST_ZERO: begin
                w_we = 1'b1;
            end
            ST_IDLE: begin
                w_we    = i_cmd_valid && (i_cmd.op == OP_WRITE);
                w_addr  = i_cmd.addr;
                w_wdata = i_cmd.data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr[$clog2(CELLS)-1:0]] <= w_wdata;
        end
        r_rdata <= r_mem[i_cmd.addr[$clog2(CELLS)-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_cnt   <= '0;
            r_zcol  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_FILL: begin
                    r_cnt <= r_cnt + ADDR_W'(1);
                    if (r_cnt == ADDR_W'(CELLS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cell     <= '0;
                        r_col      <= i_cmd.col;
                        r_row      <= i_cmd.row;
                        r_scrolled <= i_cmd.scroll;
                        r_bad      <= i_cmd.bad;
                        if (i_cmd.op == OP_READ) begin
                            r_state <= ST_READ;
                        end else if (i_cmd.scroll) begin
                            r_state <= ST_ZERO;
                            r_cnt   <= i_cmd.clr_addr;
                            r_zcol  <= '0;
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                end
                ST_READ: begin
                    r_cell  <= r_rdata;
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                ST_ZERO: begin
                    r_cnt  <= r_cnt + ADDR_W'(1);
                    r_zcol <= r_zcol + COL_W'(1);
                    if (r_zcol == COL_W'(COLUMNS - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_FILL;
                end
            endcase
        end
    end

    assign o_done          = r_done;
    assign o_cell_value    = r_cell;
    assign o_cursor_column = r_col;
    assign o_cursor_row    = r_row;
    assign o_scrolled      = r_scrolled;
    assign o_bad_position  = r_bad;

endmodule

// ===== rtl/text_console_cursor_scroll.sv =====
// Top level of the text console: config register, front end, queue, back end.
// Depends on tccs_pkg, tccs_front, tccs_fifo, tccs_back, assert_macros.svh.
//
// Usage:
//   Items enter on start/i_kind/... and are taken at a clock edge with start
//   high and busy low. Each item gives one result word, shown for one cycle
//   with o_done high; the receiver cannot hold it off.
//   text_color is written over the APB port at byte address 0.
// Path from accept to o_done: the item is registered in the queue, then the
//   back end takes it in its idle state and registers the result; a read
//   goes through the read state first, a put that scrolls through the row-clear
//   state, which writes the cells of the freed row one after another (single memory write port).
// Throughput: one write per cycle while the queue keeps up; a read or a
//   scroll holds the back end in its read or row-clear state. The queue
//   of two commands lets items be taken during that time until it fills.
// Scrolling moves a base-row pointer; only the freed row is cleared.
// Reset: cursor to 0, text_color to 7, then a fill pass writes every cell
//   with a light-grey blank, during which busy is high. APB writes are
//   taken at any time.
`include "assert_macros.svh"

module text_console_cursor_scroll
    import tccs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [BYTE_W-1:0]  i_char_code,
    input  logic [BYTE_W-1:0]  i_entry_color,
    input  logic [COL_W-1:0]   i_pos_column,
    input  logic [ROW_W-1:0]   i_pos_row,
    output logic               o_done,
    output logic [CELL_W-1:0]  o_cell_value,
    output logic [COL_W-1:0]   o_cursor_column,
    output logic [ROW_W-1:0]   o_cursor_row,
    output logic               o_scrolled,
    output logic               o_bad_position,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [BYTE_W-1:0] r_text_color;

    logic w_accept;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_valid;
    logic w_q_full;
    t_cmd w_q_cmd;
    logic w_pop;
    logic w_clearing;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TEXT_COLOR) ? PDATA_W'(r_text_color) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= TEXT_COLOR_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_COLOR)) begin
            r_text_color <= pwdata[BYTE_W-1:0];
        end
    end

    assign busy     = w_clearing || w_q_full;
    assign w_accept = start && !busy;

    tccs_front #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_entry_color(i_entry_color),
        .i_pos_column (i_pos_column),
        .i_pos_row    (i_pos_row),
        .i_text_color (r_text_color),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    tccs_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_push_cmd),
        .i_pop  (w_pop),
        .o_valid(w_q_valid),
        .o_full (w_q_full),
        .o_cmd  (w_q_cmd)
    );

    tccs_back #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_q_valid),
        .i_cmd          (w_q_cmd),
        .o_pop          (w_pop),
        .o_clearing     (w_clearing),
        .o_done         (o_done),
        .o_cell_value   (o_cell_value),
        .o_cursor_column(o_cursor_column),
        .o_cursor_row   (o_cursor_row),
        .o_scrolled     (o_scrolled),
        .o_bad_position (o_bad_position)
    );

    `ASSERT_STD(a_no_done_in_fill, w_clearing |-> !o_done, "result during fill pass")
    `ASSERT_STD(a_queue_empty_after_fill, $fell(w_clearing) |-> !w_q_valid, "queue not empty after fill")
    `ASSERT_STD(a_scroll_cursor, (o_done && o_scrolled) |-> (o_cursor_column == '0 && o_cursor_row == ROW_W'(ROWS - 1)), "bad cursor after scroll")
    `ASSERT_STD(a_bad_pos_result, (o_done && o_bad_position) |-> (o_cell_value == '0 && !o_scrolled), "bad position result not clean")

endmodule

// ===== tb/sv/text_console_cursor_scroll_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for text_console_cursor_scroll: queued command words,
// a shadow screen and cursor predicting every result, APB writes of text_color.
// Depends on tccs_pkg and the text_console_cursor_scroll RTL.
module text_console_cursor_scroll_tb;
    import tccs_pkg::*;

    localparam int COLUMNS = DEF_COLUMNS;
    localparam int ROWS    = DEF_ROWS;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] attr;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } console_word_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_val;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              scrolled;
        logic              bad;
    } console_result_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    console_word_t      cur_word;
    logic               o_done;
    logic [CELL_W-1:0]  o_cell_value;
    logic [COL_W-1:0]   o_cursor_column;
    logic [ROW_W-1:0]   o_cursor_row;
    logic               o_scrolled;
    logic               o_bad_position;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    text_console_cursor_scroll #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_kind(cur_word.kind),
        .i_char_code(cur_word.ch),
        .i_entry_color(cur_word.attr),
        .i_pos_column(cur_word.col),
        .i_pos_row(cur_word.row),
        .o_done(o_done),
        .o_cell_value(o_cell_value),
        .o_cursor_column(o_cursor_column),
        .o_cursor_row(o_cursor_row),
        .o_scrolled(o_scrolled),
        .o_bad_position(o_bad_position),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    console_word_t     pending_words[$];
    console_result_t   due_results[$];
    logic [CELL_W-1:0] screen_shadow [0:COLUMNS*ROWS-1];
    logic [BYTE_W-1:0] color_shadow;
    int                cur_x;
    int                cur_y;
    int                planned_words;
    int                mismatches;
    int                idle_cycles;
    int                burst_left;
    int                gap_left;
    bit                word_taken;

    always #5 i_clk = ~i_clk;

    task automatic update_screen(input console_word_t w, output console_result_t r);
        int c;
        bit on_screen;
        r = '0;
        on_screen = (w.col < COLUMNS) && (w.row < ROWS);
        case (w.kind)
            KIND_PUT: begin
                if (w.ch == NEWLINE_CODE) begin
                    cur_x = 0;
                    cur_y = (cur_y + 1 >= ROWS) ? 0 : cur_y + 1;
                end else begin
                    screen_shadow[cur_y*COLUMNS + cur_x] = {color_shadow, w.ch};
                    cur_x++;
                    if (cur_x >= COLUMNS) begin
                        cur_x = 0;
                        cur_y++;
                        if (cur_y >= ROWS) begin
                            for (c = 0; c < (ROWS-1)*COLUMNS; c++)
                                screen_shadow[c] = screen_shadow[c + COLUMNS];
                            for (c = (ROWS-1)*COLUMNS; c < ROWS*COLUMNS; c++)
                                screen_shadow[c] = '0;
                            cur_y = ROWS - 1;
                            r.scrolled = 1'b1;
                        end
                    end
                end
            end
            KIND_CELL: begin
                if (on_screen)
                    screen_shadow[w.row*COLUMNS + w.col] = {w.attr, w.ch};
                else
                    r.bad = 1'b1;
            end
            KIND_READ: begin
                if (on_screen)
                    r.cell_val = screen_shadow[w.row*COLUMNS + w.col];
                else
                    r.bad = 1'b1;
            end
            default: ;
        endcase
        r.col = COL_W'(cur_x);
        r.row = ROW_W'(cur_y);
    endtask

    task automatic flag_result(input string what, input console_result_t want,
                               input console_result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s: expected cell=%h col=%0d row=%0d scr=%0b bad=%0b",
                     what, want.cell_val, want.col, want.row, want.scrolled, want.bad);
            $display("%s: got      cell=%h col=%0d row=%0d scr=%0b bad=%0b",
                     what, got.cell_val, got.col, got.row, got.scrolled, got.bad);
        end
    endtask

    // word monitor, result checker and watchdog
    always @(posedge i_clk) begin : monitor
        console_result_t got;
        console_result_t pred;
        word_taken = i_rst_n && start && !busy;
        if (i_rst_n && o_done) begin
            got = {o_cell_value, o_cursor_column, o_cursor_row, o_scrolled, o_bad_position};
            if (due_results.size() == 0)
                flag_result("unexpected word", '0, got);
            else begin
                pred = due_results.pop_front();
                if (got != pred)
                    flag_result("mismatch", pred, got);
            end
        end
        if (word_taken) begin
            update_screen(cur_word, pred);
            due_results.push_back(pred);
        end
        if (word_taken || o_done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // word driver: bursts of random length, random gaps between them
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || word_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_words.size() != 0) begin
                cur_word <= pending_words.pop_front();
                start <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    case ($urandom_range(0, 7))
                        0, 1, 2: gap_left = 0;
                        3, 4, 5: gap_left = $urandom_range(1, 4);
                        6:       gap_left = $urandom_range(5, 12);
                        default: gap_left = $urandom_range(20, 90);
                    endcase
                end else begin
                    burst_left--;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic push_word(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] ch,
                             input logic [BYTE_W-1:0] attr, input logic [COL_W-1:0] col,
                             input logic [ROW_W-1:0] row);
        pending_words.push_back('{kind, ch, attr, col, row});
        planned_words++;
    endtask

    function automatic logic [BYTE_W-1:0] text_byte();
        logic [BYTE_W-1:0] b;
        do b = $urandom; while (b == NEWLINE_CODE);
        return b;
    endfunction

    task automatic push_text(input logic [BYTE_W-1:0] ch);
        push_word(KIND_PUT, ch, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || start || due_results.size() != 0);
    endtask

    task automatic write_text_color(input logic [BYTE_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TEXT_COLOR, 2'b00};
        pwdata  <= {{(PDATA_W-BYTE_W){1'b0}}, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        color_shadow = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // needs an idle block: walks the cursor down from the shadow position
    task automatic plan_scroll(input bit with_wrap);
        repeat (ROWS - 1 - cur_y) push_text(NEWLINE_CODE);
        if (with_wrap) begin
            push_text(text_byte());
            push_text(text_byte());
            push_text(NEWLINE_CODE);
            repeat (ROWS - 1) push_text(NEWLINE_CODE);
        end
        repeat (COLUMNS + $urandom_range(0, 8)) push_text(text_byte());
        push_word(KIND_READ, $urandom, $urandom, 0, ROWS - 1);
        push_word(KIND_READ, $urandom, $urandom, COLUMNS - 1, ROWS - 1);
        push_word(KIND_READ, $urandom, $urandom, 0, ROWS - 2);
    endtask

    task automatic random_mix(input int count);
        int stop_at;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        stop_at = planned_words + count;
        while (planned_words < stop_at) begin
            col = $urandom_range(0, COLUMNS - 1);
            row = $urandom_range(0, ROWS - 1);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 30)) push_text(text_byte());
                    if ($urandom_range(0, 1)) push_text(NEWLINE_CODE);
                end
                3: repeat ($urandom_range(1, 5)) push_text(NEWLINE_CODE);
                4, 5: begin
                    push_word(KIND_CELL, $urandom, $urandom, col, row);
                    push_word(KIND_READ, $urandom, $urandom, col, row);
                end
                6: push_word(KIND_READ, $urandom, $urandom, col, row);
                7: push_word($urandom, $urandom, $urandom, $urandom, $urandom);
                8: begin
                    if ($urandom_range(0, 1))
                        col = $urandom_range(COLUMNS, 127);
                    else
                        row = $urandom_range(ROWS, 31);
                    push_word($urandom_range(0, 1) ? KIND_CELL : KIND_READ,
                              $urandom, $urandom, col, row);
                end
                default: push_word(KIND_SPARE, $urandom, $urandom, $urandom, $urandom);
            endcase
        end
    endtask

    initial begin
        i_clk     = 1'b0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        cur_word  = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        burst_left = 0;
        gap_left   = 0;
        foreach (screen_shadow[i]) screen_shadow[i] = BLANK_CELL;
        color_shadow = TEXT_COLOR_RST;
        cur_x = 0;
        cur_y = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // blank screen after reset, corners, off-screen positions, unused kind
        push_word(KIND_READ, 8'h00, 8'h00, 0, 0);
        push_word(KIND_READ, 8'hFF, 8'hFF, COLUMNS - 1, ROWS - 1);
        push_word(KIND_READ, 8'h00, 8'h00, COLUMNS, 0);
        push_word(KIND_READ, 8'h00, 8'h00, 0, ROWS);
        push_word(KIND_READ, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
        push_word(KIND_CELL, 8'hFF, 8'hFF, 0, 0);
        push_word(KIND_CELL, 8'h00, 8'h00, COLUMNS - 1, ROWS - 1);
        push_word(KIND_CELL, 8'hAA, 8'h55, 7'h7F, 5'h1F);
        push_word(KIND_CELL, 8'h55, 8'hAA, COLUMNS - 1, ROWS);
        push_word(KIND_READ, 8'h00, 8'h00, 0, 0);
        push_word(KIND_READ, 8'h00, 8'h00, COLUMNS - 1, ROWS - 1);
        push_word(KIND_PUT, 8'h48, 8'h00, 0, 0);
        push_word(KIND_PUT, 8'h00, 8'hFF, 7'h7F, 5'h1F);
        push_word(KIND_PUT, 8'hFF, 8'h00, 0, 0);
        push_word(KIND_PUT, NEWLINE_CODE, 8'h00, 0, 0);
        push_word(KIND_SPARE, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
        push_word(KIND_SPARE, 8'h00, 8'h00, 0, 0);
        push_word(KIND_READ, 8'h00, 8'h00, 0, 0);
        push_word(KIND_READ, 8'h00, 8'h00, 2, 0);
        wait_idle();

        // newline wrap on the bottom row, then scrolls at the reset color
        plan_scroll(1'b1);
        random_mix(50);
        wait_idle();

        write_text_color(8'hFF);
        plan_scroll(1'b0);
        random_mix(50);
        wait_idle();

        write_text_color(8'h00);
        plan_scroll(1'b0);
        random_mix(50);
        wait_idle();

        write_text_color($urandom);
        plan_scroll(1'b0);
        random_mix(50);
        wait_idle();

        repeat (COLUMNS + 4) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
